// ===== rtl/core/drrb_pkg.sv =====
package drrb_pkg;

  localparam int DMA_DEPTH  = 64;
  localparam int RING_DEPTH = 256;
  localparam int MAX_READ   = 16;

  localparam int DMA_AW  = $clog2(DMA_DEPTH);
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CAP_W   = 9;
  localparam int POS_W   = 7;
  localparam int LIM_W   = 5;
  localparam int ACC_W   = 7;
  localparam int OVF_W   = 16;
  localparam int FILL_W  = 8;

  typedef enum logic [1:0] {
    CMD_DMA_BYTE = 2'd0,
    CMD_POSITION = 2'd1,
    CMD_READ     = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    KIND_DATA        = 3'd0,
    KIND_EMPTY       = 3'd1,
    KIND_POS_DONE    = 3'd2,
    KIND_POS_IGNORED = 3'd3,
    KIND_ACK         = 3'd4
  } kind_t;

  typedef struct packed {
    logic  load;
    logic  copy;
    logic  pos_finish;
    logic  rd_pop;
    logic  emit;
    kind_t emit_kind;
  } drrb_cmd_t;

  typedef struct packed {
    logic pos_over;
    logic seg_end;
    logic wrap;
    logic cnt_zero;
    logic cnt_last;
  } drrb_stat_t;

endpackage

// ===== rtl/core/dma_rx_ring_bridge.sv =====
// Receive DMA to byte ring bridge.
// Beats enter on start while busy is low, with in_cmd selecting the action:
// a DMA byte write, a position event, a read request, or a restart.
// Every beat answers with one or more results, each shown for exactly one
// cycle while out_strobe is high; out_last_of_run marks the final result.
// A DMA byte or restart answers via the S_ACK state and the output register.
// A position event copies one byte per cycle from the 64-entry DMA store into
// the ring while the ring has room, then answers via the S_PDONE state and the
// output register; this copy loop sets the rate.
// Read requests return one byte per cycle via S_READ and the output register.
// The block holds busy high until its last result is issued, and takes the
// next beat in the cycle that result is shown.
// The receiver cannot stall, so results are never held back.
// The cfg_we port rewrites the ring capacity and empties the ring.
// Reset empties the ring, clears the last position and the overflow count,
// and sets the capacity to 256.
module dma_rx_ring_bridge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_dma_index,
  input  logic [7:0]  in_dma_byte,
  input  logic [6:0]  in_position,
  input  logic [4:0]  in_read_limit,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_read_data,
  output logic        out_last_of_run,
  output logic [6:0]  out_bytes_accepted,
  output logic [15:0] out_overflow_total,
  output logic [7:0]  out_fill_level
);
  import drrb_pkg::*;

  drrb_cmd_t  cmd;
  drrb_stat_t stat;

  drrb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  drrb_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_dma_index       (in_dma_index),
    .in_dma_byte        (in_dma_byte),
    .in_position        (in_position),
    .in_read_limit      (in_read_limit),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_read_data      (out_read_data),
    .out_last_of_run    (out_last_of_run),
    .out_bytes_accepted (out_bytes_accepted),
    .out_overflow_total (out_overflow_total),
    .out_fill_level     (out_fill_level)
  );

endmodule

// ===== rtl/core/drrb_ctrl.sv =====
module drrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [1:0]             in_cmd,
  input  drrb_pkg::drrb_stat_t   stat,
  output drrb_pkg::drrb_cmd_t    cmd,
  output logic                   busy
);
  import drrb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ACK   = 6'b000010,
    S_IGN   = 6'b000100,
    S_COPY  = 6'b001000,
    S_PDONE = 6'b010000,
    S_READ  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.emit_kind  = KIND_ACK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (cmd_code_t'(in_cmd))
            CMD_DMA_BYTE: state_nxt = S_ACK;
            CMD_RESTART:  state_nxt = S_ACK;
            CMD_POSITION: state_nxt = stat.pos_over ? S_IGN : S_COPY;
            CMD_READ:     state_nxt = S_READ;
          endcase
        end
      end
      S_ACK: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_ACK;
        state_nxt     = S_IDLE;
      end
      S_IGN: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_POS_IGNORED;
        state_nxt     = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.seg_end && !stat.wrap) begin
          state_nxt = S_PDONE;
        end
      end
      S_PDONE: begin
        cmd.pos_finish = 1'b1;
        cmd.emit       = 1'b1;
        cmd.emit_kind  = KIND_POS_DONE;
        state_nxt      = S_IDLE;
      end
      S_READ: begin
        cmd.emit = 1'b1;
        if (stat.cnt_zero) begin
          cmd.emit_kind = KIND_EMPTY;
          state_nxt     = S_IDLE;
        end else begin
          cmd.emit_kind = KIND_DATA;
          cmd.rd_pop    = 1'b1;
          if (stat.cnt_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not leave idle");

  a_empty_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ && stat.cnt_zero |=> state_r == S_IDLE)
    else $error("empty read did not end the run");

endmodule

// ===== rtl/core/drrb_dpath.sv =====
module drrb_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  drrb_pkg::drrb_cmd_t  cmd,
  output drrb_pkg::drrb_stat_t stat,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_wdata,
  input  logic [1:0]           in_cmd,
  input  logic [5:0]           in_dma_index,
  input  logic [7:0]           in_dma_byte,
  input  logic [6:0]           in_position,
  input  logic [4:0]           in_read_limit,
  output logic                 out_strobe,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_read_data,
  output logic                 out_last_of_run,
  output logic [6:0]           out_bytes_accepted,
  output logic [15:0]          out_overflow_total,
  output logic [7:0]           out_fill_level
);
  import drrb_pkg::*;

  logic [7:0] dma_mem  [DMA_DEPTH];
  logic [7:0] ring_mem [RING_DEPTH];

  logic [DMA_AW-1:0]  src_r, src_nxt, last_r, last_nxt;
  logic [POS_W-1:0]   rem_r, rem_nxt, pos_r, pos_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               wrap_r, wrap_nxt;
  logic [RING_AW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [OVF_W-1:0]   ovf_r, ovf_nxt;
  logic [LIM_W-1:0]   cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  fill_after_r, fill_after_nxt;
  logic [7:0]         dma_q_r, ring_q_r;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic [ACC_W-1:0]   out_acc_r, out_acc_nxt;
  logic [OVF_W-1:0]   out_ovf_r, out_ovf_nxt;
  logic [FILL_W-1:0]  out_fill_r, out_fill_nxt;

  logic [CAP_W-1:0]   wr_plus, rd_plus, fill_wide, cap_wr;
  logic [RING_AW-1:0] wr_inc, rd_inc;
  logic [FILL_W-1:0]  fill_now;
  logic [LIM_W-1:0]   lim_clamp, rd_count;
  logic               full, ring_we;

  always_comb begin
    wr_plus   = CAP_W'(wr_r) + CAP_W'(1);
    rd_plus   = CAP_W'(rd_r) + CAP_W'(1);
    wr_inc    = (wr_plus >= cap_r) ? '0 : wr_plus[RING_AW-1:0];
    rd_inc    = (rd_plus >= cap_r) ? '0 : rd_plus[RING_AW-1:0];
    full      = (wr_inc == rd_r);
    fill_wide = (wr_r >= rd_r) ? (CAP_W'(wr_r) - CAP_W'(rd_r))
                               : (cap_r - CAP_W'(rd_r) + CAP_W'(wr_r));
    fill_now  = fill_wide[FILL_W-1:0];
    lim_clamp = (in_read_limit > LIM_W'(MAX_READ)) ? LIM_W'(MAX_READ) : in_read_limit;
    rd_count  = (FILL_W'(lim_clamp) < fill_now) ? lim_clamp : fill_now[LIM_W-1:0];
    if (cfg_wdata < CAP_W'(2)) begin
      cap_wr = CAP_W'(2);
    end else if (cfg_wdata > CAP_W'(RING_DEPTH)) begin
      cap_wr = CAP_W'(RING_DEPTH);
    end else begin
      cap_wr = cfg_wdata;
    end
    ring_we = cmd.copy && (rem_r != '0) && !full;
  end

  always_comb begin
    src_nxt        = src_r;
    last_nxt       = last_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    wrap_nxt       = wrap_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    cap_nxt        = cap_r;
    ovf_nxt        = ovf_r;
    cnt_nxt        = cnt_r;
    fill_after_nxt = fill_after_r;

    if (cmd.load) begin
      unique case (cmd_code_t'(in_cmd))
        CMD_DMA_BYTE: begin
        end
        CMD_POSITION: begin
          src_nxt = last_r;
          pos_nxt = in_position;
          acc_nxt = '0;
          if (in_position >= POS_W'(last_r)) begin
            rem_nxt  = in_position - POS_W'(last_r);
            wrap_nxt = 1'b0;
          end else begin
            rem_nxt  = POS_W'(DMA_DEPTH) - POS_W'(last_r);
            wrap_nxt = 1'b1;
          end
        end
        CMD_READ: begin
          cnt_nxt        = rd_count;
          fill_after_nxt = fill_now - FILL_W'(rd_count);
        end
        CMD_RESTART: begin
          rd_nxt   = '0;
          wr_nxt   = '0;
          last_nxt = '0;
          ovf_nxt  = '0;
        end
      endcase
    end

    if (cmd.copy) begin
      if (rem_r == '0) begin
        if (wrap_r) begin
          src_nxt  = '0;
          rem_nxt  = pos_r;
          wrap_nxt = 1'b0;
        end
      end else if (full) begin
        ovf_nxt = ovf_r + OVF_W'(1);
        if (wrap_r) begin
          src_nxt  = '0;
          rem_nxt  = pos_r;
          wrap_nxt = 1'b0;
        end else begin
          rem_nxt = '0;
        end
      end else begin
        wr_nxt  = wr_inc;
        src_nxt = src_r + DMA_AW'(1);
        rem_nxt = rem_r - POS_W'(1);
        acc_nxt = acc_r + ACC_W'(1);
      end
    end

    if (cmd.pos_finish) begin
      last_nxt = (pos_r == POS_W'(DMA_DEPTH)) ? '0 : pos_r[DMA_AW-1:0];
    end

    if (cmd.rd_pop) begin
      rd_nxt  = rd_inc;
      cnt_nxt = cnt_r - LIM_W'(1);
    end

    if (cfg_we) begin
      cap_nxt = cap_wr;
      rd_nxt  = '0;
      wr_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = cmd.emit;
    out_kind_nxt  = cmd.emit_kind;
    out_data_nxt  = (cmd.emit_kind == KIND_DATA) ? ring_q_r : '0;
    out_last_nxt  = (cmd.emit_kind != KIND_DATA) || (cnt_r == LIM_W'(1));
    out_acc_nxt   = (cmd.emit_kind == KIND_POS_DONE) ? acc_r : '0;
    out_ovf_nxt   = ovf_r;
    out_fill_nxt  = (cmd.emit_kind == KIND_DATA) ? fill_after_r : fill_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      cap_r       <= CAP_W'(RING_DEPTH);
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      cap_r       <= cap_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    acc_r        <= acc_nxt;
    wrap_r       <= wrap_nxt;
    cnt_r        <= cnt_nxt;
    fill_after_r <= fill_after_nxt;
    if (cmd.emit) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_acc_r  <= out_acc_nxt;
      out_ovf_r  <= out_ovf_nxt;
      out_fill_r <= out_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (cmd_code_t'(in_cmd) == CMD_DMA_BYTE)) begin
      dma_mem[in_dma_index[DMA_AW-1:0]] <= in_dma_byte;
    end
    dma_q_r <= dma_mem[src_nxt];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_r] <= dma_q_r;
    end
    ring_q_r <= ring_mem[rd_nxt];
  end

  always_comb begin
    stat.pos_over = (in_position > POS_W'(DMA_DEPTH));
    stat.seg_end  = (rem_r == '0) || full;
    stat.wrap     = wrap_r;
    stat.cnt_zero = (cnt_r == '0);
    stat.cnt_last = (cnt_r == LIM_W'(1));
  end

  assign out_strobe         = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_read_data      = out_data_r;
  assign out_last_of_run    = out_last_r;
  assign out_bytes_accepted = out_acc_r;
  assign out_overflow_total = out_ovf_r;
  assign out_fill_level     = out_fill_r;

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(rd_r) < cap_r && CAP_W'(wr_r) < cap_r)
    else $error("ring pointer beyond capacity");

  a_overflow_bump: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy && (rem_r != '0) && full |=> ovf_r == $past(ovf_r) + OVF_W'(1))
    else $error("full segment did not count an overflow");

  a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != KIND_DATA) |-> out_last_r)
    else $error("single result not marked last");

endmodule
